@@ src/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg
// Types and constants shared by the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // Input item: orientation quaternion, signed Q1.14 components
  typedef struct packed {
    logic signed [15:0] quat_real;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
  } quat_t;

  // Result item: yaw, pitch, roll and the zero-norm flag
  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic               invalid;
  } euler_t;

  // Products and squares in Q2.28, handed from front to back
  typedef struct packed {
    logic signed [31:0] p_ij;
    logic signed [31:0] p_kr;
    logic signed [31:0] p_jr;
    logic signed [31:0] p_ik;
    logic signed [31:0] p_jk;
    logic signed [31:0] p_ir;
    logic [30:0]        sq_r;
    logic [30:0]        sq_i;
    logic [30:0]        sq_j;
    logic [30:0]        sq_k;
    logic               zero;
  } prod_t;

  // Arctangent arguments for yaw and roll
  typedef struct packed {
    logic signed [33:0] yaw_y;
    logic signed [33:0] yaw_x;
    logic signed [33:0] roll_y;
    logic signed [33:0] roll_x;
  } args_t;

  // Per-item flags that ride along the back pipeline
  typedef struct packed {
    logic inv;
    logic sat;
    logic neg;
  } flags_t;

  localparam int ARG_W        = 34;
  localparam int ANG_W        = 35;
  localparam int CORDIC_XW    = 54;
  localparam int CORDIC_SCALE = 16;
  localparam int DIV_STEPS    = 28;
  localparam int SQRT_STEPS   = 29;
  localparam int ATAN_LEN     = 24;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic [30:0]             DEG100_MUL  = 31'd1501974482;
  localparam logic [14:0]             ANGLE_LIMIT = 15'd25736;

  // atan(2^-i) in radians Q2.30
  localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

endpackage

@@ src/q2e_fifo.sv @@
// ----------------------------------------------------------------------------
// q2e_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module q2e_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the pushed transaction
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/q2e_front.sv @@
// ----------------------------------------------------------------------------
// q2e_front
// Accepts quaternions, forms all products and squares, flags zero input.
// ----------------------------------------------------------------------------
module q2e_front import q2e_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  quat_t quat,
  output logic  mid_push,
  output prod_t prod,
  input  logic  mid_full
);

  logic               vld;
  logic               load;
  prod_t              prod_next;
  logic signed [31:0] sq_r;
  logic signed [31:0] sq_i;
  logic signed [31:0] sq_j;
  logic signed [31:0] sq_k;

  assign load     = !vld || !mid_full;
  assign full     = !load;
  assign mid_push = vld && !mid_full;

  // Form products and squares of the incoming components
  always_comb begin
    sq_r = 32'(quat.quat_real) * 32'(quat.quat_real);
    sq_i = 32'(quat.quat_i) * 32'(quat.quat_i);
    sq_j = 32'(quat.quat_j) * 32'(quat.quat_j);
    sq_k = 32'(quat.quat_k) * 32'(quat.quat_k);
    prod_next.p_ij = 32'(quat.quat_i) * 32'(quat.quat_j);
    prod_next.p_kr = 32'(quat.quat_k) * 32'(quat.quat_real);
    prod_next.p_jr = 32'(quat.quat_j) * 32'(quat.quat_real);
    prod_next.p_ik = 32'(quat.quat_i) * 32'(quat.quat_k);
    prod_next.p_jk = 32'(quat.quat_j) * 32'(quat.quat_k);
    prod_next.p_ir = 32'(quat.quat_i) * 32'(quat.quat_real);
    prod_next.sq_r = sq_r[30:0];
    prod_next.sq_i = sq_i[30:0];
    prod_next.sq_j = sq_j[30:0];
    prod_next.sq_k = sq_k[30:0];
    prod_next.zero = (quat.quat_real == '0) && (quat.quat_i == '0) &&
                     (quat.quat_j == '0) && (quat.quat_k == '0);
  end

  // Hold the stage while the queue is full
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (load && push) begin
      prod <= prod_next;
    end
  end

endmodule

@@ src/q2e_cordic.sv @@
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring arctangent, one iteration per stage, angle in Q2.30.
// ----------------------------------------------------------------------------
module q2e_cordic import q2e_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ARG_W-1:0] y_in,
  input  logic signed [ARG_W-1:0] x_in,
  output logic signed [ANG_W-1:0] z_out
);

  localparam int XW = CORDIC_XW;

  logic signed [XW-1:0]    x  [0:STEPS];
  logic signed [XW-1:0]    y  [0:STEPS];
  logic signed [ANG_W-1:0] z  [0:STEPS];
  logic                    zf [0:STEPS];

  logic signed [XW-1:0]    xe;
  logic signed [XW-1:0]    ye;
  logic signed [ANG_W-1:0] z0;

  // Fold the left half plane onto the right, seed the angle with pi
  always_comb begin
    xe = XW'(x_in);
    ye = XW'(y_in);
    z0 = '0;
    if (x_in < 0) begin
      z0 = (y_in >= 0) ? PI_Q30 : -PI_Q30;
      xe = -xe;
      ye = -ye;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= xe <<< CORDIC_SCALE;
      y[0]  <= ye <<< CORDIC_SCALE;
      z[0]  <= z0;
      zf[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  // Rotate toward the x axis, one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_it
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (y[i] > 0) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + $signed(ANG_W'(ATAN_TAB[i]));
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - $signed(ANG_W'(ATAN_TAB[i]));
        end
        zf[i+1] <= zf[i];
      end
    end
  end

  // Undetermined angle reads as zero
  assign z_out = zf[STEPS] ? '0 : z[STEPS];

endmodule

@@ src/q2e_convert.sv @@
// ----------------------------------------------------------------------------
// q2e_convert
// Scales a Q2.30 angle to hundredths of degree or radians times 8192.
// ----------------------------------------------------------------------------
module q2e_convert import q2e_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    deg,
  input  logic signed [ANG_W-1:0] z_in,
  output logic signed [15:0]      angle
);

  logic        neg0;
  logic [32:0] m0;
  logic        neg1;
  logic [32:0] m1;
  logic [47:0] pp_lo;
  logic [46:0] pp_hi;
  logic        neg2;
  logic [14:0] mag2;

  logic [64:0] dfull;
  logic [33:0] rsum;
  logic [16:0] mag;

  // Take the magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      neg0 <= z_in[ANG_W-1];
      m0   <= z_in[ANG_W-1] ? 33'(-z_in) : 33'(z_in);
    end
  end

  // Split the degree scaling into two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= neg0;
      m1    <= m0;
      pp_lo <= 48'(m0[16:0]) * 48'(DEG100_MUL);
      pp_hi <= 47'(m0[32:17]) * 47'(DEG100_MUL);
    end
  end

  // Round half away from zero and saturate
  always_comb begin
    dfull = 65'(pp_lo) + (65'(pp_hi) << 17) + (65'd1 << 47);
    rsum  = 34'(m1) + (34'd1 << 16);
    mag   = deg ? dfull[64:48] : rsum[33:17];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      mag2 <= (mag > 17'(ANGLE_LIMIT)) ? ANGLE_LIMIT : mag[14:0];
    end
  end

  // Restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      angle <= neg2 ? 16'(-{1'b0, mag2}) : {1'b0, mag2};
    end
  end

endmodule

@@ src/q2e_back.sv @@
// ----------------------------------------------------------------------------
// q2e_back
// Angle pipeline: sums, arcsine quotient and root, three arctangents, scaling.
// ----------------------------------------------------------------------------
module q2e_back import q2e_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_empty,
  input  prod_t  in_data,
  output logic   in_pop,
  input  logic   deg,
  input  logic   out_full,
  output logic   out_push,
  output euler_t out_data
);

  localparam int ST_DIV_END = 1 + DIV_STEPS;
  localparam int ST_SQ      = ST_DIV_END + 1;
  localparam int ST_V       = ST_SQ + 1;
  localparam int ST_PRE     = ST_V + SQRT_STEPS;
  localparam int ST_CZ      = ST_PRE + 1 + CORDIC_STEPS;
  localparam int LAST       = ST_CZ + 4;
  localparam logic [57:0] ONE_Q56 = 58'd1 << 56;

  logic           en;
  logic [LAST:0]  vld;
  flags_t         flg [0:LAST];

  args_t              ang [0:ST_PRE];
  args_t              ang0_next;
  logic signed [33:0] pnum_q;
  logic [32:0]        norm_q;
  logic signed [33:0] pnum_next;
  logic [32:0]        norm_next;
  logic signed [33:0] s_r;
  logic signed [33:0] s_i;
  logic signed [33:0] s_j;
  logic signed [33:0] s_k;

  logic               neg1;
  logic [32:0]        mag1;
  logic               sat1;

  logic [34:0]            rem [1:ST_DIV_END];
  logic [32:0]            den [1:ST_DIV_END];
  logic [DIV_STEPS-1:0]   quo [1:ST_DIV_END];
  logic [DIV_STEPS-1:0]   s_sq;
  logic [55:0]            s2;
  logic [57:0]            sr_v [ST_V:ST_PRE];
  logic [57:0]            sr_r [ST_V:ST_PRE];
  logic [DIV_STEPS-1:0]   sr_s [ST_V:ST_PRE];

  logic signed [ARG_W-1:0] py;
  logic signed [ARG_W-1:0] px;
  logic signed [ANG_W-1:0] z_yaw;
  logic signed [ANG_W-1:0] z_pitch;
  logic signed [ANG_W-1:0] z_roll;
  logic signed [ANG_W-1:0] pz;
  logic signed [15:0]      a_yaw;
  logic signed [15:0]      a_pitch;
  logic signed [15:0]      a_roll;

  // Advance everything unless a finished result cannot leave
  assign en       = !vld[LAST] || !out_full;
  assign in_pop   = en && !in_empty;
  assign out_push = vld[LAST] && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], !in_empty};
    end
  end

  // Form the arctangent and arcsine arguments
  always_comb begin
    s_r = $signed(34'(in_data.sq_r));
    s_i = $signed(34'(in_data.sq_i));
    s_j = $signed(34'(in_data.sq_j));
    s_k = $signed(34'(in_data.sq_k));
    ang0_next.yaw_y  = (34'(in_data.p_ij) + 34'(in_data.p_kr)) <<< 1;
    ang0_next.yaw_x  = s_i - s_j - s_k + s_r;
    ang0_next.roll_y = (34'(in_data.p_jk) + 34'(in_data.p_ir)) <<< 1;
    ang0_next.roll_x = s_r - s_i - s_j + s_k;
    pnum_next        = (34'(in_data.p_jr) - 34'(in_data.p_ik)) <<< 1;
    norm_next        = 33'(in_data.sq_r) + 33'(in_data.sq_i) +
                       33'(in_data.sq_j) + 33'(in_data.sq_k);
  end

  // Split the arcsine argument into sign and magnitude, detect overrange
  always_comb begin
    neg1 = pnum_q[33];
    mag1 = neg1 ? 33'(-pnum_q) : 33'(pnum_q);
    sat1 = (mag1 >= norm_q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang[0] <= ang0_next;
      pnum_q <= pnum_next;
      norm_q <= norm_next;
      for (int k = 1; k <= ST_PRE; k++) begin
        ang[k] <= ang[k-1];
      end
      rem[1] <= 35'(mag1);
      den[1] <= norm_q;
      quo[1] <= '0;
    end
  end

  // Carry the flags alongside the data
  always_ff @(posedge clk) begin
    if (en) begin
      flg[0].inv <= in_data.zero;
      flg[0].sat <= 1'b0;
      flg[0].neg <= 1'b0;
      flg[1].inv <= flg[0].inv;
      flg[1].sat <= sat1;
      flg[1].neg <= neg1;
      for (int k = 2; k <= LAST; k++) begin
        flg[k] <= flg[k-1];
      end
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar k = 2; k <= ST_DIV_END; k++) begin : g_div
    logic [34:0] r2;
    logic        qb;
    assign r2 = {rem[k-1][33:0], 1'b0};
    assign qb = (r2 >= 35'(den[k-1]));

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= qb ? r2 - 35'(den[k-1]) : r2;
        den[k] <= den[k-1];
        quo[k] <= {quo[k-1][DIV_STEPS-2:0], qb};
      end
    end
  end

  // Square the sine, then form one minus its square
  always_ff @(posedge clk) begin
    if (en) begin
      s_sq       <= quo[ST_DIV_END];
      s2         <= 56'(quo[ST_DIV_END]) * 56'(quo[ST_DIV_END]);
      sr_v[ST_V] <= ONE_Q56 - 58'(s2);
      sr_r[ST_V] <= '0;
      sr_s[ST_V] <= s_sq;
    end
  end

  // Digit-by-digit square root, one result bit per stage
  for (genvar k = ST_V + 1; k <= ST_PRE; k++) begin : g_sqrt
    localparam int J = k - ST_V - 1;
    localparam logic [57:0] B = 58'd1 << (2 * (SQRT_STEPS - 1) - 2 * J);
    logic [57:0] t;
    logic        ge;
    assign t  = sr_r[k-1] + B;
    assign ge = (sr_v[k-1] >= t);

    always_ff @(posedge clk) begin
      if (en) begin
        sr_v[k] <= ge ? sr_v[k-1] - t : sr_v[k-1];
        sr_r[k] <= ge ? (sr_r[k-1] >> 1) + B : sr_r[k-1] >> 1;
        sr_s[k] <= sr_s[k-1];
      end
    end
  end

  assign py = flg[ST_PRE].neg ? -$signed(34'(sr_s[ST_PRE])) : $signed(34'(sr_s[ST_PRE]));
  assign px = $signed(34'(sr_r[ST_PRE]));

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (ang[ST_PRE].yaw_y),
    .x_in  (ang[ST_PRE].yaw_x),
    .z_out (z_yaw)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (py),
    .x_in  (px),
    .z_out (z_pitch)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (ang[ST_PRE].roll_y),
    .x_in  (ang[ST_PRE].roll_x),
    .z_out (z_roll)
  );

  // Overrange arcsine gives exactly plus or minus half pi
  assign pz = flg[ST_CZ].sat ? (flg[ST_CZ].neg ? -HALF_PI_Q30 : HALF_PI_Q30) : z_pitch;

  q2e_convert u_conv_yaw (
    .clk   (clk),
    .en    (en),
    .deg   (deg),
    .z_in  (z_yaw),
    .angle (a_yaw)
  );

  q2e_convert u_conv_pitch (
    .clk   (clk),
    .en    (en),
    .deg   (deg),
    .z_in  (pz),
    .angle (a_pitch)
  );

  q2e_convert u_conv_roll (
    .clk   (clk),
    .en    (en),
    .deg   (deg),
    .z_in  (z_roll),
    .angle (a_roll)
  );

  // Zero quaternion drops all angles to zero
  always_comb begin
    out_data.invalid     = flg[LAST].inv;
    out_data.yaw_angle   = flg[LAST].inv ? '0 : a_yaw;
    out_data.pitch_angle = flg[LAST].inv ? '0 : a_pitch;
    out_data.roll_angle  = flg[LAST].inv ? '0 : a_roll;
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST] && !en) |=> (vld[LAST] && $stable(out_data)))
    else $error("stalled result lost or changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST] && out_data.invalid) |->
      (out_data.yaw_angle == '0 && out_data.pitch_angle == '0 && out_data.roll_angle == '0))
    else $error("invalid result carries nonzero angles");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] |->
      (out_data.yaw_angle <= 16'sd25736 && out_data.yaw_angle >= -16'sd25736 &&
       out_data.pitch_angle <= 16'sd25736 && out_data.pitch_angle >= -16'sd25736 &&
       out_data.roll_angle <= 16'sd25736 && out_data.roll_angle >= -16'sd25736))
    else $error("angle outside saturation limit");

endmodule

@@ src/quaternion_to_euler.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Path: front products, middle queue, the 28-stage divider, 29-stage root,
//   the CORDIC stages, angle scaling and the output queue.
// Throughput: one quaternion per cycle unless a queue fills; fully pipelined.
// Reset: synchronous; clears queues and valid bits, degrees_mode returns to 1.
// Converts a Q1.14 quaternion into yaw, pitch and roll.
// ----------------------------------------------------------------------------
module quaternion_to_euler import q2e_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  quat_t  quat,
  input  logic   pop,
  output logic   empty,
  output euler_t angles,
  input  logic   cfg_valid,
  output logic   cfg_ready,
  input  logic   cfg_data
);

  logic   degrees_mode;
  logic   mid_push;
  logic   mid_full;
  logic   mid_empty;
  logic   mid_pop;
  prod_t  front_prod;
  prod_t  mid_prod;
  logic   out_full;
  logic   out_push;
  euler_t back_res;

  assign cfg_ready = 1'b1;

  // Take a configuration transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      degrees_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      degrees_mode <= cfg_data;
    end
  end

  q2e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .quat     (quat),
    .mid_push (mid_push),
    .prod     (front_prod),
    .mid_full (mid_full)
  );

  q2e_fifo #(.WIDTH($bits(prod_t)), .DEPTH(4)) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (front_prod),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_prod),
    .empty   (mid_empty)
  );

  q2e_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_empty (mid_empty),
    .in_data  (mid_prod),
    .in_pop   (mid_pop),
    .deg      (degrees_mode),
    .out_full (out_full),
    .out_push (out_push),
    .out_data (back_res)
  );

  q2e_fifo #(.WIDTH($bits(euler_t)), .DEPTH(4)) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (back_res),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (angles),
    .empty   (empty)
  );

endmodule

@@ tb/q2e_checker.sv @@
// ----------------------------------------------------------------------------
// q2e_checker
// Watches the quaternion and angle queues of the converter, predicts yaw,
// pitch, roll and the zero-norm flag for every accepted quaternion, and
// compares each popped result against the oldest prediction.
// ----------------------------------------------------------------------------
module q2e_checker import q2e_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  logic   full,
  input  quat_t  quat,
  input  logic   pop,
  input  logic   empty,
  input  euler_t angles,
  input  logic   cfg_valid,
  input  logic   cfg_ready,
  input  logic   cfg_data,
  output int     fail_count,
  output int     pending,
  output int     result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PI_FX      = 64'd3373259426;
  localparam longint HALF_PI_FX = 64'd1686629713;
  localparam longint DEG_MUL    = 64'd1501974482;
  localparam longint LIMIT      = 64'd25736;

  euler_t angle_queue[$];
  bit     deg_mode;

  // Shift right with floor rounding on negatives
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vector_atan(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_FX : -PI_FX;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arcsine(longint num, longint den);
    bit neg;
    longint unsigned m, s, c;
    neg = num < 0;
    m = neg ? -num : num;
    if (m >= longint'(den)) return neg ? -HALF_PI_FX : HALF_PI_FX;
    s = (m << 28) / den;
    c = int_root((64'd1 << 56) - s * s);
    return vector_atan(neg ? -longint'(s) : longint'(s), longint'(c));
  endfunction

  // Scale Q2.30 radians to output units, round half away, saturate
  function automatic logic signed [15:0] to_units(longint z);
    bit neg;
    longint unsigned m;
    neg = z < 0;
    m = neg ? -z : z;
    if (deg_mode) m = (m * DEG_MUL + (64'd1 << 47)) >> 48;
    else m = (m + (64'd1 << 16)) >> 17;
    if (m > LIMIT) m = LIMIT;
    return neg ? -16'(m) : 16'(m);
  endfunction

  function automatic euler_t predict_angles(quat_t q);
    euler_t e;
    longint r, a, b, c, sr, sa, sb, sc, nrm;
    r = q.quat_real; a = q.quat_i; b = q.quat_j; c = q.quat_k;
    sr = r * r; sa = a * a; sb = b * b; sc = c * c;
    nrm = sr + sa + sb + sc;
    e = '0;
    if (nrm == 0) begin
      e.invalid = 1'b1;
      return e;
    end
    e.yaw_angle   = to_units(vector_atan(2 * (a * b + c * r), sa - sb - sc + sr));
    e.pitch_angle = to_units(arcsine(2 * (b * r - a * c), nrm));
    e.roll_angle  = to_units(vector_atan(2 * (b * c + a * r), -sa - sb + sc + sr));
    return e;
  endfunction

  assign pending = angle_queue.size();

  // Track mode, predict on push, compare on pop
  always @(posedge clk) begin
    euler_t want;
    if (rst) begin
      deg_mode = 1'b1;
      angle_queue.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (push && !full) angle_queue.push_back(predict_angles(quat));
      if (pop && !empty) begin
        result_count++;
        if (angle_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %h", $time, angles);
        end else begin
          want = angle_queue.pop_front();
          if (want.yaw_angle !== angles.yaw_angle) begin
            fail_count++;
            $display("%0t: yaw expected %0d actual %0d", $time, want.yaw_angle,
                     angles.yaw_angle);
          end
          if (want.pitch_angle !== angles.pitch_angle) begin
            fail_count++;
            $display("%0t: pitch expected %0d actual %0d", $time, want.pitch_angle,
                     angles.pitch_angle);
          end
          if (want.roll_angle !== angles.roll_angle) begin
            fail_count++;
            $display("%0t: roll expected %0d actual %0d", $time, want.roll_angle,
                     angles.roll_angle);
          end
          if (want.invalid !== angles.invalid) begin
            fail_count++;
            $display("%0t: invalid expected %0b actual %0b", $time, want.invalid,
                     angles.invalid);
          end
        end
      end
      // Mode write lands after this edge's pushes are predicted
      if (cfg_valid && cfg_ready) deg_mode = cfg_data;
    end
  end
endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives quaternions into the converter under random idling and backpressure,
// switches between degree and radian output, and reports the checker verdict.
// ----------------------------------------------------------------------------
module testbench;
  import q2e_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 84;
  localparam int WATCHDOG = 5000;

  logic   clk, rst, push, full, pop, empty, cfg_valid, cfg_ready, cfg_data;
  quat_t  quat;
  euler_t angles;
  int     fail_count, pending, result_count, idle_cycles, sent;
  bit     calm, hold_sink;

  quaternion_to_euler uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .quat(quat),
    .pop(pop), .empty(empty), .angles(angles),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  q2e_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .quat(quat),
    .pop(pop), .empty(empty), .angles(angles),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drain results; idle at random unless held or calm
  initial begin
    pop = 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      pop <= !hold_sink && (calm || $urandom_range(99) >= 14);
    end
  end

  // Stop the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("quaternion_to_euler verification failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // Offer one quaternion until accepted, with random idle cycles first;
  // push stays high afterwards so items can follow back to back
  task automatic send_quat(quat_t q);
    while (!calm && $urandom_range(99) < 14) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    quat <= q;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic drain;
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(64)) - 16'd32;
      3: return 16'h4000 + 16'($urandom_range(512)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // Quaternion from extreme, small, near-one and arbitrary components, sometimes gimbal lock
  function automatic quat_t rand_quat();
    quat_t q;
    q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    if ($urandom_range(9) == 0) begin
      q.quat_real = 16'sd11585 + 16'($urandom_range(6)) - 16'sd3;
      q.quat_j = q.quat_real;
      q.quat_i = 16'($urandom_range(4)) - 16'sd2;
      q.quat_k = q.quat_i;
    end
    return q;
  endfunction

  initial begin
    quat_t dir [$];
    rst = 1'b1; push = 1'b0; quat = '0; cfg_valid = 1'b0; cfg_data = 1'b0;
    calm = 1'b0; hold_sink = 1'b0; sent = 0; idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Extremes, zero quaternion, gimbal lock, arcsine overrange, axis cases
    dir = '{ '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0},
             '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
             '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
             '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0},
             '{16'sd11585, 16'sd0, -16'sd11585, 16'sd0},
             '{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0},
             '{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0},
             '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768},
             '{-16'sd1, 16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd1, 16'sd1},
             '{16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384} };
    foreach (dir[n]) send_quat(dir[n]);
    set_mode(1'b0);
    foreach (dir[n]) send_quat(dir[n]);
    set_mode(1'b1);
    // Random phase with backpressure: block the sink while offering
    fork
      begin
        hold_sink = 1'b1;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      repeat (200) send_quat(rand_quat());
    join
    // Quiet stretch, then alternating mode swaps with a full drain before each
    calm = 1'b1;
    repeat (200) send_quat(rand_quat());
    calm = 1'b0;
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0]);
      repeat (90) send_quat(rand_quat());
    end
    drain();
    $display("Sent %0d quaternions, checked %0d angle sets in both angle units,",
             sent, result_count);
    $display("with backpressure, idle gaps and zero, full-scale and gimbal-lock inputs.");
    if (fail_count == 0) $display("quaternion_to_euler verification clean");
    else $display("quaternion_to_euler verification failed");
    $finish;
  end
endmodule
